// ===== hdl/fdef_pkg.sv =====
package fdef_pkg;

    localparam int SECTOR_BYTES_DEFAULT = 512;
    localparam int ENTRY_BYTES = 32;
    localparam int OFF_W = $clog2(ENTRY_BYTES);
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CLUSTER_W = 28;

    localparam logic [7:0] MARK_DELETED = 8'hE5;
    localparam logic [7:0] MARK_END = 8'h00;
    localparam logic [7:0] ATTR_HIDDEN_MASK = 8'h0E;
    localparam logic [7:0] ATTR_DIR = 8'h10;
    localparam logic [7:0] CLUS_TOP_MASK = 8'h0F;

    // Byte offsets inside one directory entry.
    localparam logic [OFF_W-1:0] OFF_FIRST = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_ATTR = OFF_W'(11);
    localparam logic [OFF_W-1:0] OFF_CLUS_HI_LO = OFF_W'(20);
    localparam logic [OFF_W-1:0] OFF_CLUS_HI_HI = OFF_W'(21);
    localparam logic [OFF_W-1:0] OFF_CLUS_LO_LO = OFF_W'(26);
    localparam logic [OFF_W-1:0] OFF_CLUS_LO_HI = OFF_W'(27);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(ENTRY_BYTES - 1);

    typedef enum logic [1:0] {
        REQ_START    = 2'd0,
        REQ_DATA     = 2'd1,
        REQ_READ_ERR = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_e;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_ENTRY = 2'd0,
        CFG_SECTORS      = 2'd1,
        CFG_FAT32_MODE   = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_index_e;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic                 found;
        logic [CLUSTER_W-1:0] start_cluster;
        logic                 is_directory;
    } out_word_t;

    typedef struct packed {
        logic [15:0] target_entry;
        logic [7:0]  sectors_per_cluster;
        logic        fat32_mode;
    } cfg_t;

endpackage

// ===== hdl/fat_directory_entry_finder.sv =====
// FAT directory entry finder.
// The input channel (in_valid, in_stall, in_word) carries one request word per
// cycle unless stalled: a start word opens a search, data words bring the
// directory cluster bytes in order, and a read-error word aborts the search.
// The finder counts the visible 32-byte entries and, when the target entry
// completes, sends one output word (out_valid, out_stall, out_word) with the
// start cluster and the directory flag. End-of-directory marks, the end of the
// cluster, read errors and a target entry with a zero cluster that is not a
// directory produce a single not-found word instead. A word is registered on
// acceptance and judged from the input register, and its result is held in
// the output register on out_valid until it is taken.
// One word is accepted every cycle in which in_stall is low; the scan state is
// a set of counters and byte captures updated once per word.
// When the receiver stalls, the result stays in the output register, the scan
// pauses, and the input side stalls while a word waits in the input register.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready
// and is meant to be written between searches.
// Reset clears all control state, returns to idle and loads target entry 1,
// one sector per cluster and FAT32 mode.
module fat_directory_entry_finder #(
    parameter int SECTOR_BYTES = fdef_pkg::SECTOR_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  fdef_pkg::in_word_t                in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output fdef_pkg::out_word_t               out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fdef_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fdef_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fdef_pkg::*;

    cfg_t      cfg;
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      advance;
    logic      res_valid;
    out_word_t res;

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_word = out_word_reg;

    fdef_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fdef_scan #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (in_valid_reg && advance),
        .word      (in_word_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_word;
        if (advance && in_valid_reg && res_valid)
            out_word_reg <= res;
    end

endmodule

// ===== hdl/fdef_cfg_regs.sv =====
module fdef_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fdef_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fdef_pkg::CFG_DATA_W-1:0]     cfg_data,
    output fdef_pkg::cfg_t                      cfg
);
    import fdef_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_e'(cfg_index))
                CFG_TARGET_ENTRY: cfg_next.target_entry = cfg_data;
                CFG_SECTORS:      cfg_next.sectors_per_cluster = cfg_data[7:0];
                CFG_FAT32_MODE:   cfg_next.fat32_mode = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_entry <= 16'd1;
            cfg_reg.sectors_per_cluster <= 8'd1;
            cfg_reg.fat32_mode <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/fdef_scan.sv =====
module fdef_scan #(
    parameter int SECTOR_BYTES = fdef_pkg::SECTOR_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 proc,
    input  fdef_pkg::in_word_t   word,
    input  fdef_pkg::cfg_t       cfg,
    output logic                 res_valid,
    output fdef_pkg::out_word_t  res
);
    import fdef_pkg::*;

    localparam int BW = $clog2(SECTOR_BYTES);
    localparam int EVAL_LIMIT = SECTOR_BYTES - (SECTOR_BYTES % ENTRY_BYTES);
    localparam logic [BW-1:0] LAST_BYTE = BW'(SECTOR_BYTES - 1);
    localparam logic [BW:0] EVAL_LIMIT_C = (BW + 1)'(EVAL_LIMIT);

    logic                 searching_reg, searching_next;
    logic [BW-1:0]        byte_reg, byte_next;
    logic [7:0]           sector_reg, sector_next;
    logic [15:0]          visible_reg, visible_next;
    logic [7:0]           first_reg, first_next;
    logic [7:0]           attr_reg, attr_next;
    logic [CLUSTER_W-1:0] clus_reg, clus_next;

    logic [OFF_W-1:0]     off;
    logic [7:0]           b;
    logic [15:0]          vis_inc;
    logic [8:0]           sector_inc;
    logic                 eval;
    logic                 visible;
    logic                 dir;
    logic                 matched;

    assign off = byte_reg[OFF_W-1:0];
    assign b = word.data_byte;
    assign vis_inc = visible_reg + 16'd1;
    assign sector_inc = {1'b0, sector_reg} + 9'd1;

    always_comb
    begin
        searching_next = searching_reg;
        byte_next = byte_reg;
        sector_next = sector_reg;
        visible_next = visible_reg;
        first_next = first_reg;
        attr_next = attr_reg;
        clus_next = clus_reg;
        res_valid = 1'b0;
        res = '0;
        eval = 1'b0;
        visible = 1'b0;
        dir = 1'b0;
        matched = 1'b0;

        if (proc)
        begin
            case (req_e'(word.req_type))
                REQ_START:
                begin
                    searching_next = 1'b1;
                    byte_next = '0;
                    sector_next = '0;
                    visible_next = '0;
                    first_next = '0;
                    attr_next = '0;
                    clus_next = '0;
                end
                REQ_READ_ERR:
                begin
                    if (searching_reg)
                    begin
                        res_valid = 1'b1;
                        searching_next = 1'b0;
                    end
                end
                REQ_DATA:
                begin
                    if (searching_reg)
                    begin
                        case (off)
                            OFF_FIRST:
                            begin
                                first_next = b;
                                attr_next = '0;
                                clus_next = '0;
                            end
                            OFF_ATTR: attr_next = b;
                            OFF_CLUS_HI_LO:
                                if (cfg.fat32_mode)
                                    clus_next = clus_reg | {4'd0, b, 16'd0};
                            OFF_CLUS_HI_HI:
                                if (cfg.fat32_mode)
                                    clus_next = clus_reg
                                                | {b[3:0] & CLUS_TOP_MASK[3:0], 24'd0};
                            OFF_CLUS_LO_LO: clus_next = clus_reg | {20'd0, b};
                            OFF_CLUS_LO_HI: clus_next = clus_reg | {12'd0, b, 8'd0};
                            default: ;
                        endcase

                        if (off == OFF_FIRST && b == MARK_END)
                        begin
                            res_valid = 1'b1;
                            searching_next = 1'b0;
                        end
                        else
                        begin
                            // The decision on an entry falls on its last byte; a partial
                            // entry at the tail of a ragged sector is never judged.
                            eval = (off == OFF_LAST) && ({1'b0, byte_reg} < EVAL_LIMIT_C);
                            visible = (first_next != MARK_DELETED) &&
                                      ((attr_next & ATTR_HIDDEN_MASK) == 8'd0);
                            dir = (attr_next & ATTR_DIR) != 8'd0;
                            if (eval && visible)
                            begin
                                visible_next = vis_inc;
                                if (cfg.target_entry != 16'd0 && vis_inc == cfg.target_entry)
                                begin
                                    matched = 1'b1;
                                    res_valid = 1'b1;
                                    searching_next = 1'b0;
                                    if (clus_next != '0 || dir)
                                    begin
                                        res.found = 1'b1;
                                        res.start_cluster = clus_next;
                                        res.is_directory = dir;
                                    end
                                end
                            end

                            if (!matched)
                            begin
                                if (byte_reg == LAST_BYTE)
                                begin
                                    byte_next = '0;
                                    sector_next = sector_inc[7:0];
                                    if (sector_inc >= {1'b0, cfg.sectors_per_cluster})
                                    begin
                                        res_valid = 1'b1;
                                        searching_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    byte_next = byte_reg + BW'(1);
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            searching_reg <= 1'b0;
            byte_reg <= '0;
            sector_reg <= '0;
            visible_reg <= '0;
            first_reg <= '0;
            attr_reg <= '0;
            clus_reg <= '0;
        end
        else
        begin
            searching_reg <= searching_next;
            byte_reg <= byte_next;
            sector_reg <= sector_next;
            visible_reg <= visible_next;
            first_reg <= first_next;
            attr_reg <= attr_next;
            clus_reg <= clus_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !searching_reg)
        else $error("search still running after a result");

    a_found_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.found) |-> (res.start_cluster != '0 || res.is_directory))
        else $error("found entry with zero cluster that is not a directory");

    a_not_found_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.found) |-> (res.start_cluster == '0 && !res.is_directory))
        else $error("not-found word carries a payload");

    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> searching_reg)
        else $error("result produced while idle");
`endif

endmodule
